// ----- rtl/llfw_pkg.sv -----
`default_nettype none
package llfw_pkg;

	// Number of entries in the arctangent table
	localparam int ATAN_N = 24;
	// Angle accumulator width (32-bit turn plus guard bits)
	localparam int ZW = 34;
	// Q4.30 vector component width
	localparam int CW = 34;

	localparam logic signed [CW-1:0] KGAIN      = 34'sd652032874;
	localparam logic [30:0]          TWO_PI_Q28 = 31'd1686629713;
	localparam logic signed [ZW-1:0] QUARTER    = 34'sd1073741824;
	localparam logic signed [ZW-1:0] HALF       = 34'sd2147483648;

	localparam logic [29:0] ATAN_TAB [ATAN_N] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81
	};

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_RADIAL_GAIN  = 3'd2,
		REG_CENTRE_X     = 3'd3,
		REG_CENTRE_Y     = 3'd4,
		REG_ROT_X        = 3'd5,
		REG_ROT_Y        = 3'd6,
		REG_ROT_Z        = 3'd7
	} reg_idx_t;

	// Rotation matrix, Q4.30 entries
	typedef struct packed {
		logic signed [CW-1:0] m00, m01, m02;
		logic signed [CW-1:0] m10, m11, m12;
		logic signed [CW-1:0] m20, m21, m22;
	} rmat_t;

	function automatic logic signed [ZW-1:0] atan_at(input int i);
		return $signed(ZW'(ATAN_TAB[i]));
	endfunction

	// Q4.30 product, floor rounding
	function automatic logic signed [CW-1:0] fmul(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] p;
		p = a * b;
		return p[CW+29:30];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/llfw_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per stage; keeps the low QW quotient bits
module llfw_div import llfw_pkg::*; #(
	parameter int NW = 30,
	parameter int DW = 15,
	parameter int QW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          ce,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               out_valid,
	output logic [QW-1:0]      quo
);

	logic [NW:0]   vld_s;
	logic [NW-1:0] num_s [NW+1];
	logic [DW-1:0] rem_s [NW+1];
	logic [QW-1:0] quo_s [NW+1];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[NW-1:0], in_valid};
		end
	end

	// input stage
	always_ff @(posedge clk) begin
		if (ce) begin
			num_s[0] <= num;
			rem_s[0] <= '0;
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0]   trial;
		logic          ge;
		logic [DW-1:0] rem_n;
		always_comb begin
			trial = {rem_s[k], num_s[k][NW-1]};
			ge    = trial >= {1'b0, den};
			rem_n = ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				num_s[k+1] <= num_s[k] << 1;
				rem_s[k+1] <= rem_n;
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign quo       = quo_s[NW];

endmodule
`default_nettype wire

// ----- rtl/llfw_cordic_rot.sv -----
`default_nettype none
// Rotation-mode CORDIC: cos and sin of a 16-bit binary angle, one step per stage
module llfw_cordic_rot import llfw_pkg::*; #(
	parameter int STAGES = 16,
	parameter int TAGW   = 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            ce,
	input  wire logic            in_valid,
	input  wire logic [15:0]     ang,
	input  wire logic [TAGW-1:0] tag_in,
	output logic                 out_valid,
	output logic signed [CW-1:0] cos_o,
	output logic signed [CW-1:0] sin_o,
	output logic [TAGW-1:0]      tag_o
);

	localparam int N = (STAGES > ATAN_N) ? ATAN_N : STAGES;

	logic [N:0]           vld_s;
	logic signed [CW-1:0] x_s [N+1];
	logic signed [CW-1:0] y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];
	logic                 neg_s [N+1];
	logic [TAGW-1:0]      tag_s [N+1];

	logic signed [ZW-1:0] z_full, z_fold;
	logic                 neg_fold;

	// fold into [-quarter, +quarter], negate the result when folded
	always_comb begin
		z_full   = $signed({{(ZW-32){ang[15]}}, ang, 16'b0});
		z_fold   = z_full;
		neg_fold = 1'b0;
		if (z_full > QUARTER) begin
			z_fold   = z_full - HALF;
			neg_fold = 1'b1;
		end else if (z_full < -QUARTER) begin
			z_fold   = z_full + HALF;
			neg_fold = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_valid <= 1'b0;
		end else if (ce) begin
			vld_s     <= {vld_s[N-1:0], in_valid};
			out_valid <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			x_s[0]   <= KGAIN;
			y_s[0]   <= '0;
			z_s[0]   <= z_fold;
			neg_s[0] <= neg_fold;
			tag_s[0] <= tag_in;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_iter
		logic signed [CW-1:0] xn, yn;
		logic signed [ZW-1:0] zn;
		always_comb begin
			if (z_s[k] >= 0) begin
				xn = x_s[k] - (y_s[k] >>> k);
				yn = y_s[k] + (x_s[k] >>> k);
				zn = z_s[k] - atan_at(k);
			end else begin
				xn = x_s[k] + (y_s[k] >>> k);
				yn = y_s[k] - (x_s[k] >>> k);
				zn = z_s[k] + atan_at(k);
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				x_s[k+1]   <= xn;
				y_s[k+1]   <= yn;
				z_s[k+1]   <= zn;
				neg_s[k+1] <= neg_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	// output stage, undo the fold
	always_ff @(posedge clk) begin
		if (ce) begin
			cos_o <= neg_s[N] ? -x_s[N] : x_s[N];
			sin_o <= neg_s[N] ? -y_s[N] : y_s[N];
			tag_o <= tag_s[N];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/llfw_cordic_vec.sv -----
`default_nettype none
// Vectoring-mode CORDIC: angle (32-bit turn units, unwrapped) and length of (x, y)
module llfw_cordic_vec import llfw_pkg::*; #(
	parameter int STAGES = 16,
	parameter int XW     = 36,
	parameter int TAGW   = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              ce,
	input  wire logic              in_valid,
	input  wire logic signed [XW-1:0] x_in,
	input  wire logic signed [XW-1:0] y_in,
	input  wire logic [TAGW-1:0]   tag_in,
	output logic                   out_valid,
	output logic signed [ZW-1:0]   ang_o,
	output logic signed [XW+1:0]   mag_o,
	output logic [TAGW-1:0]        tag_o
);

	localparam int N  = (STAGES > ATAN_N) ? ATAN_N : STAGES;
	localparam int IW = XW + 2;

	logic [N:0]           vld_s;
	logic signed [IW-1:0] x_s [N+1];
	logic signed [IW-1:0] y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];
	logic                 zero_s [N+1];
	logic [TAGW-1:0]      tag_s [N+1];

	logic signed [IW-1:0] xe, ye, x0, y0;
	logic signed [ZW-1:0] z0;
	logic signed [IW+CW-1:0] mp;

	// a vector in the left half-plane is first turned by a quarter
	always_comb begin
		xe = IW'(x_in);
		ye = IW'(y_in);
		x0 = xe;
		y0 = ye;
		z0 = '0;
		if (xe < 0) begin
			if (ye >= 0) begin
				x0 = ye;
				y0 = -xe;
				z0 = QUARTER;
			end else begin
				x0 = -ye;
				y0 = xe;
				z0 = -QUARTER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_valid <= 1'b0;
		end else if (ce) begin
			vld_s     <= {vld_s[N-1:0], in_valid};
			out_valid <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			x_s[0]    <= x0;
			y_s[0]    <= y0;
			z_s[0]    <= z0;
			zero_s[0] <= (x_in == 0) && (y_in == 0);
			tag_s[0]  <= tag_in;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_iter
		logic signed [IW-1:0] xn, yn;
		logic signed [ZW-1:0] zn;
		always_comb begin
			if (y_s[k] < 0) begin
				xn = x_s[k] - (y_s[k] >>> k);
				yn = y_s[k] + (x_s[k] >>> k);
				zn = z_s[k] - atan_at(k);
			end else begin
				xn = x_s[k] + (y_s[k] >>> k);
				yn = y_s[k] - (x_s[k] >>> k);
				zn = z_s[k] + atan_at(k);
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				x_s[k+1]    <= xn;
				y_s[k+1]    <= yn;
				z_s[k+1]    <= zn;
				zero_s[k+1] <= zero_s[k];
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	// gain correction of the length
	assign mp = x_s[N] * KGAIN;

	always_ff @(posedge clk) begin
		if (ce) begin
			ang_o <= zero_s[N] ? '0 : z_s[N];
			mag_o <= zero_s[N] ? '0 : mp[IW+29:30];
			tag_o <= tag_s[N];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/llfw_rotmat.sv -----
`default_nettype none
// Free-running build of the Euler rotation matrix from the three angle registers
module llfw_rotmat import llfw_pkg::*; #(
	parameter int STAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] rot_x,
	input  wire logic [15:0] rot_y,
	input  wire logic [15:0] rot_z,
	output rmat_t            mat
);

	logic signed [CW-1:0] cx, sx, cy, sy, cz, sz;
	logic signed [CW-1:0] czcy_s1, szcy_s1, szcx_s1, czsy_s1, szsy_s1;
	logic signed [CW-1:0] czcx_s1, cysx_s1, szsx_s1, czsx_s1, cycx_s1;
	logic signed [CW-1:0] sx_s1, cx_s1, sy_s1;
	rmat_t                mat_s2;

	llfw_cordic_rot #(.STAGES(STAGES), .TAGW(1)) u_rx (
		.clk(clk), .arst_n(arst_n), .ce(1'b1), .in_valid(1'b1), .ang(rot_x),
		.tag_in(1'b0), .out_valid(), .cos_o(cx), .sin_o(sx), .tag_o()
	);
	llfw_cordic_rot #(.STAGES(STAGES), .TAGW(1)) u_ry (
		.clk(clk), .arst_n(arst_n), .ce(1'b1), .in_valid(1'b1), .ang(rot_y),
		.tag_in(1'b0), .out_valid(), .cos_o(cy), .sin_o(sy), .tag_o()
	);
	llfw_cordic_rot #(.STAGES(STAGES), .TAGW(1)) u_rz (
		.clk(clk), .arst_n(arst_n), .ce(1'b1), .in_valid(1'b1), .ang(rot_z),
		.tag_in(1'b0), .out_valid(), .cos_o(cz), .sin_o(sz), .tag_o()
	);

	// first-level products
	always_ff @(posedge clk) begin
		czcy_s1 <= fmul(cz, cy);
		szcy_s1 <= fmul(sz, cy);
		szcx_s1 <= fmul(sz, cx);
		czsy_s1 <= fmul(cz, sy);
		szsy_s1 <= fmul(sz, sy);
		czcx_s1 <= fmul(cz, cx);
		cysx_s1 <= fmul(cy, sx);
		szsx_s1 <= fmul(sz, sx);
		czsx_s1 <= fmul(cz, sx);
		cycx_s1 <= fmul(cy, cx);
		sx_s1   <= sx;
		cx_s1   <= cx;
		sy_s1   <= sy;
	end

	// second-level products and sums
	always_ff @(posedge clk) begin
		mat_s2.m00 <= czcy_s1;
		mat_s2.m01 <= szcy_s1;
		mat_s2.m02 <= -sy_s1;
		mat_s2.m10 <= -szcx_s1 + fmul(czsy_s1, sx_s1);
		mat_s2.m11 <= czcx_s1 + fmul(szsy_s1, sx_s1);
		mat_s2.m12 <= cysx_s1;
		mat_s2.m20 <= szsx_s1 + fmul(czsy_s1, cx_s1);
		mat_s2.m21 <= -czsx_s1 + fmul(szsy_s1, cx_s1);
		mat_s2.m22 <= cycx_s1;
	end

	assign mat = mat_s2;

endmodule
`default_nettype wire

// ----- rtl/latlong_to_fisheye_coordinate_warp.sv -----
`default_nettype none
// Path: the 30-stage longitude/latitude divider, then four CORDIC pipelines in
// series.
// Throughput: one item per cycle; the whole pipeline holds while a result waits
// and m_tready is low.
// Reset: arst_n clears all valid bits and loads the register reset values; the
// rotation matrix settles through its CORDICs and product registers after reset or an angle write.
module latlong_to_fisheye_coordinate_warp import llfw_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // pixel_x[13:0], pixel_y[27:14], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // source_x[23:0], source_y[47:24]
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	logic [14:0]        width_q, height_q;
	logic [31:0]        gain_q;
	logic signed [23:0] centre_x_q, centre_y_q;
	logic [15:0]        rot_x_q, rot_y_q, rot_z_q;

	logic ce;
	logic [14:0] w_eff, h_eff;
	logic        lon_dv, lat_dv;
	logic [15:0] lon_q, lat_q;
	logic        lon_rv, lat_rv;
	logic signed [CW-1:0] cl, sl, cn, sn;
	rmat_t       mat;

	logic                 v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [CW-1:0] vx_s2, vy_s2, vz_s2;
	logic signed [CW-1:0] px0_s3, px1_s3, px2_s3, py0_s3, py1_s3, py2_s3;
	logic signed [CW-1:0] pz0_s3, pz1_s3, pz2_s3;
	logic signed [35:0]   rx_s4, ry_s4, rz_s4;

	logic                 th_v, ph_v, tv;
	logic signed [ZW-1:0] th_ang, ph_ang;
	logic signed [37:0]   rxy;
	logic [35:0]          rz_t;
	logic [15:0]          th16_t;

	logic signed [ZW-1:0] ph_c;
	logic [15:0]          ph16;
	logic [46:0]          phr_p;
	logic [29:0]          phr_s5;
	logic [15:0]          th16_s5, th16_s6;
	logic [61:0]          dist_p;
	logic [25:0]          dist_s6, dist_t;
	logic signed [CW-1:0] ct, st;
	logic signed [60:0]   ox_p, oy_p;
	logic signed [30:0]   ox_s7, oy_s7;
	logic signed [31:0]   sx_sum, sy_sum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 15'd2048;
			height_q   <= 15'd1024;
			gain_q     <= 32'd65536;
			centre_x_q <= '0;
			centre_y_q <= '0;
			rot_x_q    <= '0;
			rot_y_q    <= '0;
			rot_z_q    <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q    <= cfg_wdata[14:0];
				REG_IMAGE_HEIGHT: height_q   <= cfg_wdata[14:0];
				REG_RADIAL_GAIN:  gain_q     <= cfg_wdata;
				REG_CENTRE_X:     centre_x_q <= $signed(cfg_wdata[23:0]);
				REG_CENTRE_Y:     centre_y_q <= $signed(cfg_wdata[23:0]);
				REG_ROT_X:        rot_x_q    <= cfg_wdata[15:0];
				REG_ROT_Y:        rot_y_q    <= cfg_wdata[15:0];
				REG_ROT_Z:        rot_z_q    <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// global advance: hold the data pipeline while the output item is not taken
	assign ce       = m_tready | ~m_tvalid;
	assign s_tready = ce;

	assign w_eff = (width_q == '0) ? 15'd1 : width_q;
	assign h_eff = (height_q == '0) ? 15'd1 : height_q;

	// pixel centre to binary angles
	llfw_div #(.NW(30), .DW(15), .QW(16)) u_div_lon (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(s_tvalid),
		.num({s_tdata[13:0], 1'b1, 15'b0}), .den(w_eff),
		.out_valid(lon_dv), .quo(lon_q)
	);
	llfw_div #(.NW(30), .DW(15), .QW(16)) u_div_lat (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(s_tvalid),
		.num({1'b0, s_tdata[27:14], 1'b1, 14'b0}), .den(h_eff),
		.out_valid(lat_dv), .quo(lat_q)
	);

	llfw_cordic_rot #(.STAGES(CORDIC_STAGES), .TAGW(1)) u_rot_lon (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(lon_dv),
		.ang(lon_q ^ 16'h8000), .tag_in(1'b0),
		.out_valid(lon_rv), .cos_o(cn), .sin_o(sn), .tag_o()
	);
	// latitude is offset by a quarter turn
	llfw_cordic_rot #(.STAGES(CORDIC_STAGES), .TAGW(1)) u_rot_lat (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(lat_dv),
		.ang(lat_q - 16'h4000), .tag_in(1'b0),
		.out_valid(lat_rv), .cos_o(cl), .sin_o(sl), .tag_o()
	);

	llfw_rotmat #(.STAGES(CORDIC_STAGES)) u_rotmat (
		.clk(clk), .arst_n(arst_n), .rot_x(rot_x_q), .rot_y(rot_y_q),
		.rot_z(rot_z_q), .mat(mat)
	);

	// valid bits of the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (ce) begin
			v_s2     <= lon_rv;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= ph_v;
			v_s6     <= v_s5;
			v_s7     <= tv;
			m_tvalid <= v_s7;
		end
	end

	// direction vector, matrix products, row sums
	always_ff @(posedge clk) begin
		if (ce) begin
			vx_s2  <= fmul(cl, sn);
			vy_s2  <= sl;
			vz_s2  <= fmul(cl, cn);
			px0_s3 <= fmul(vx_s2, mat.m00);
			px1_s3 <= fmul(vy_s2, mat.m10);
			px2_s3 <= fmul(vz_s2, mat.m20);
			py0_s3 <= fmul(vx_s2, mat.m01);
			py1_s3 <= fmul(vy_s2, mat.m11);
			py2_s3 <= fmul(vz_s2, mat.m21);
			pz0_s3 <= fmul(vx_s2, mat.m02);
			pz1_s3 <= fmul(vy_s2, mat.m12);
			pz2_s3 <= fmul(vz_s2, mat.m22);
			rx_s4  <= 36'(px0_s3) + 36'(px1_s3) + 36'(px2_s3);
			ry_s4  <= 36'(py0_s3) + 36'(py1_s3) + 36'(py2_s3);
			rz_s4  <= 36'(pz0_s3) + 36'(pz1_s3) + 36'(pz2_s3);
		end
	end

	// polar angle and in-plane length
	llfw_cordic_vec #(.STAGES(CORDIC_STAGES), .XW(36), .TAGW(36)) u_vec_th (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(v_s4),
		.x_in(rx_s4), .y_in(ry_s4), .tag_in(rz_s4),
		.out_valid(th_v), .ang_o(th_ang), .mag_o(rxy), .tag_o(rz_t)
	);

	// off-axis angle
	llfw_cordic_vec #(.STAGES(CORDIC_STAGES), .XW(38), .TAGW(16)) u_vec_ph (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(th_v),
		.x_in(38'($signed(rz_t))), .y_in(rxy), .tag_in(th_ang[31:16]),
		.out_valid(ph_v), .ang_o(ph_ang), .mag_o(), .tag_o(th16_t)
	);

	// clamp phi to [0, half turn], then to radians and distance
	always_comb begin
		ph_c = ph_ang;
		if (ph_ang < 0) begin
			ph_c = '0;
		end else if (ph_ang > HALF) begin
			ph_c = HALF;
		end
		ph16   = ph_c[31:16];
		phr_p  = 47'(ph16) * 47'(TWO_PI_Q28);
		dist_p = 62'(gain_q) * 62'(phr_s5);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			phr_s5  <= phr_p[45:16];
			th16_s5 <= th16_t;
			dist_s6 <= dist_p[61:36];
			th16_s6 <= th16_s5;
		end
	end

	llfw_cordic_rot #(.STAGES(CORDIC_STAGES), .TAGW(26)) u_rot_th (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(v_s6),
		.ang(th16_s6), .tag_in(dist_s6),
		.out_valid(tv), .cos_o(ct), .sin_o(st), .tag_o(dist_t)
	);

	// projection, centre offset, saturation
	assign ox_p   = $signed({1'b0, dist_t}) * ct;
	assign oy_p   = $signed({1'b0, dist_t}) * st;
	assign sx_sum = 32'(centre_x_q) + 32'(ox_s7);
	assign sy_sum = 32'(centre_y_q) + 32'(oy_s7);

	always_ff @(posedge clk) begin
		if (ce) begin
			ox_s7 <= ox_p[60:30];
			oy_s7 <= oy_p[60:30];
			if (sx_sum > 32'sd8388607) begin
				m_tdata[23:0] <= 24'h7FFFFF;
			end else if (sx_sum < -32'sd8388608) begin
				m_tdata[23:0] <= 24'h800000;
			end else begin
				m_tdata[23:0] <= sx_sum[23:0];
			end
			if (sy_sum > 32'sd8388607) begin
				m_tdata[47:24] <= 24'h7FFFFF;
			end else if (sy_sum < -32'sd8388608) begin
				m_tdata[47:24] <= 24'h800000;
			end else begin
				m_tdata[47:24] <= sy_sum[23:0];
			end
		end
	end

	// the two dividers and the two angle CORDICs run in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lon_dv == lat_dv) else $error("divider valid bits out of step");

	a_rot_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lon_rv == lat_rv) else $error("angle CORDIC valid bits out of step");

	// the valid bits v_s6 and v_s7 keep their values while ce is low
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ce |=> $stable(v_s6) && $stable(v_s7)) else $error("stage moved during hold");

endmodule
`default_nettype wire

// ----- test/latlong_to_fisheye_coordinate_warp_check.sv -----
// Watches both streams, predicts each sample position and compares in order.
module latlong_to_fisheye_coordinate_warp_check import llfw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [47:0] m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	output int               mismatches,
	output int               pending
);
	localparam int STAGES = 16;
	localparam longint K_Q30 = 652032874;
	localparam longint QTR = 64'sd1073741824;
	localparam longint HLF = 64'sd2147483648;
	localparam longint FULL = 64'sd4294967296;

	longint arctan [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	logic [14:0] width_q, height_q;
	logic [31:0] gain_q;
	logic [23:0] cx_q, cy_q;
	logic [15:0] ax_q, ay_q, az_q;
	logic [47:0] sample_queue [$];

	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> 30;
	endfunction

	// Rotation-mode CORDIC: cosine and sine of a 32-bit turn angle
	task automatic sincos(input logic [31:0] ang, output longint c, output longint s);
		longint z, x, y, nx;
		bit flip;
		z = longint'(ang);
		x = K_Q30;
		y = 0;
		flip = 0;
		if (z >= HLF) z -= FULL;
		if (z > QTR) begin
			z -= HLF; flip = 1;
		end else if (z < -QTR) begin
			z += HLF; flip = 1;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= arctan[i];
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); z += arctan[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// Vectoring-mode CORDIC: unwrapped angle and length
	task automatic arctan2(input longint x, input longint y, output longint ang,
		output longint len);
		longint z, t, nx;
		z = 0;
		if (x == 0 && y == 0) begin
			ang = 0; len = 0;
			return;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = QTR;
			end else begin
				x = -y; y = t; z = -QTR;
			end
		end
		for (int i = 0; i < STAGES; i++) begin
			if (y < 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= arctan[i];
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); z += arctan[i];
			end
			x = nx;
		end
		len = qmul(x, K_Q30);
		ang = z;
	endtask

	function automatic logic [23:0] clamp24(longint v);
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	task automatic predict_sample(input logic [13:0] px, input logic [13:0] py,
		output logic [47:0] res);
		longint w, h, cl, sl, cn, sn, cx, sx, cy, sy, cz, sz, ct, st;
		longint vx, vy, vz, rx, ry, rz, rxy, unused, th, ph, reach;
		longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
		logic [15:0] lon, lat, th16, ph16;
		longint unsigned phr, d;
		w = width_q == 0 ? 1 : width_q;
		h = height_q == 0 ? 1 : height_q;
		lon = 16'((((2 * longint'(px) + 1) << 15) / w) - 32768);
		lat = 16'((((2 * longint'(py) + 1) << 14) / h) - 16384);
		sincos({lat, 16'h0}, cl, sl);
		sincos({lon, 16'h0}, cn, sn);
		vy = sl;
		vx = qmul(cl, sn);
		vz = qmul(cl, cn);
		sincos({ax_q, 16'h0}, cx, sx);
		sincos({ay_q, 16'h0}, cy, sy);
		sincos({az_q, 16'h0}, cz, sz);
		m00 = qmul(cz, cy);
		m01 = qmul(sz, cy);
		m02 = -sy;
		m10 = -qmul(sz, cx) + qmul(qmul(cz, sy), sx);
		m11 = qmul(cz, cx) + qmul(qmul(sz, sy), sx);
		m12 = qmul(cy, sx);
		m20 = qmul(sz, sx) + qmul(qmul(cz, sy), cx);
		m21 = -qmul(cz, sx) + qmul(qmul(sz, sy), cx);
		m22 = qmul(cy, cx);
		rx = qmul(vx, m00) + qmul(vy, m10) + qmul(vz, m20);
		ry = qmul(vx, m01) + qmul(vy, m11) + qmul(vz, m21);
		rz = qmul(vx, m02) + qmul(vy, m12) + qmul(vz, m22);
		arctan2(rx, ry, th, rxy);
		th16 = th[31:16];
		arctan2(rz, rxy, ph, unused);
		if (ph < 0) ph = 0;
		if (ph > HLF) ph = HLF;
		ph16 = ph[31:16];
		phr = (longint'(ph16) * 64'd1686629713) >> 16;
		d = (longint'(gain_q) * phr) >> 36;
		if (d > 64'd2147483647) d = 64'd2147483647;
		reach = longint'(d);
		sincos({th16, 16'h0}, ct, st);
		res[23:0] = clamp24(longint'($signed(cx_q)) + ((reach * ct) >>> 30));
		res[47:24] = clamp24(longint'($signed(cy_q)) + ((reach * st) >>> 30));
	endtask

	assign pending = sample_queue.size();

	// Register shadow, input prediction and output comparison
	always @(posedge clk or negedge arst_n) begin
		logic [47:0] want;
		if (!arst_n) begin
			width_q <= 15'd2048; height_q <= 15'd1024; gain_q <= 32'd65536;
			cx_q <= '0; cy_q <= '0; ax_q <= '0; ay_q <= '0; az_q <= '0;
			sample_queue.delete();
			mismatches <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (sample_queue.size() == 0) begin
					if (mismatches < 10) $display("unexpected item %h", m_tdata);
					mismatches <= mismatches + 1;
				end else begin
					want = sample_queue.pop_front();
					if (want[23:0] !== m_tdata[23:0] || want[47:24] !== m_tdata[47:24]) begin
						if (mismatches < 10)
							$display("source x/y: expected %h/%h, got %h/%h", want[23:0],
								want[47:24], m_tdata[23:0], m_tdata[47:24]);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_sample(s_tdata[13:0], s_tdata[27:14], want);
				sample_queue.insert(sample_queue.size(), want);
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_IMAGE_WIDTH:  width_q <= cfg_wdata[14:0];
					REG_IMAGE_HEIGHT: height_q <= cfg_wdata[14:0];
					REG_RADIAL_GAIN:  gain_q <= cfg_wdata;
					REG_CENTRE_X:     cx_q <= cfg_wdata[23:0];
					REG_CENTRE_Y:     cy_q <= cfg_wdata[23:0];
					REG_ROT_X:        ax_q <= cfg_wdata[15:0];
					REG_ROT_Y:        ay_q <= cfg_wdata[15:0];
					REG_ROT_Z:        az_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- test/latlong_to_fisheye_coordinate_warp_test.sv -----
// Stimulus and verdict for the coordinate warp.
module latlong_to_fisheye_coordinate_warp_test import llfw_pkg::*;;
	localparam int LATENCY = 111;
	localparam int STALL_LIMIT = 5000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
	logic [31:0] s_tdata = '0;
	logic [47:0] m_tdata;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	int mismatches, pending;
	int idle_cycles = 0;
	bit stim_done = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	latlong_to_fisheye_coordinate_warp i_dut (.*);

	latlong_to_fisheye_coordinate_warp_check i_check (.*);

	// Receiver stalls: alternating ready and busy runs
	initial begin
		int run;
		forever begin
			run = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 6);
			repeat (run) @(posedge clk) m_tready <= 1;
			run = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 5);
			repeat (run) @(posedge clk) m_tready <= 0;
		end
	end

	// Watchdog on accepted items and register writes
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// Let the pipeline drain and the matrix settle around a register change
	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// One pixel, held until taken
	task automatic send_pixel(input logic [13:0] px, input logic [13:0] py);
		@(posedge clk);
		s_tvalid <= 1;
		s_tdata <= {4'h0, py, px};
		do @(posedge clk); while (!s_tready);
		s_tvalid <= 0;
	endtask

	task automatic send_burst(input int n, input bit in_frame);
		logic [13:0] px, py;
		for (int i = 0; i < n; i++) begin
			if (in_frame) begin
				px = 14'($urandom_range(0, 2047));
				py = 14'($urandom_range(0, 1023));
			end else begin
				px = 14'($urandom);
				py = 14'($urandom);
			end
			if (i == 0) @(posedge clk);
			s_tvalid <= 1;
			s_tdata <= {4'h0, py, px};
			do @(posedge clk); while (!s_tready);
		end
		s_tvalid <= 0;
		repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(posedge clk);
	endtask

	task automatic random_config(input bit extreme);
		write_reg(REG_IMAGE_WIDTH, extreme ? ($urandom_range(0, 1) ? 0 : 32'h7fff) :
			$urandom_range(1, 16384));
		write_reg(REG_IMAGE_HEIGHT, extreme ? ($urandom_range(0, 1) ? 1 : 32'h7fff) :
			$urandom_range(1, 16384));
		write_reg(REG_RADIAL_GAIN, extreme ? ($urandom_range(0, 1) ? 32'hffffffff : 0) :
			$urandom_range(0, 32'h00ffffff));
		write_reg(REG_CENTRE_X, $urandom);
		write_reg(REG_CENTRE_Y, $urandom);
		write_reg(REG_ROT_X, $urandom);
		write_reg(REG_ROT_Y, $urandom);
		write_reg(REG_ROT_Z, $urandom);
	endtask

	initial begin
		logic [13:0] corners [4];
		corners = '{14'd0, 14'd1, 14'd1023, 14'h3fff};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (LATENCY) @(posedge clk);

		// Directed: corner and out-of-frame pixels at reset settings, then in-frame pixels
		foreach (corners[i])
			foreach (corners[j]) send_pixel(corners[i], corners[j]);
		send_pixel(14'd1024, 14'd512);
		send_pixel(14'd2047, 14'd1023);
		drain();
		// Zero width/height, maximal gain, extreme centres, quarter-turn and near-full-turn angles
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 0);
		write_reg(REG_RADIAL_GAIN, 32'hffffffff);
		write_reg(REG_CENTRE_X, 32'h7fffff);
		write_reg(REG_CENTRE_Y, 32'h800000);
		write_reg(REG_ROT_X, 32'h4000);
		write_reg(REG_ROT_Y, 32'hc000);
		write_reg(REG_ROT_Z, 32'hffff);
		drain();
		send_pixel(14'd0, 14'd0);
		send_pixel(14'h3fff, 14'h3fff);
		send_pixel(14'h2aaa, 14'h1555);
		drain();
		write_reg(REG_IMAGE_WIDTH, 2048);
		write_reg(REG_IMAGE_HEIGHT, 1024);
		write_reg(REG_RADIAL_GAIN, 32'h00100000);
		write_reg(REG_CENTRE_X, 32'h080000);
		write_reg(REG_CENTRE_Y, 32'h040000);
		write_reg(REG_ROT_X, 32'h8000);
		write_reg(REG_ROT_Y, 32'h0000);
		write_reg(REG_ROT_Z, 32'h8000);
		drain();
		send_pixel(14'd0, 14'd0);
		send_pixel(14'd1023, 14'd511);
		send_pixel(14'd2047, 14'd1023);
		drain();

		// Random phases
		for (int phase = 0; phase < 7; phase++) begin
			random_config(phase == 2 || phase == 5);
			drain();
			for (int n = 0; n < 140;) begin
				int len;
				len = $urandom_range(1, 24);
				send_burst(len, $urandom_range(0, 3) != 0);
				n += len;
			end
			drain();
		end
		stim_done = 1;
	end

	// Verdict
	initial begin
		wait (stim_done);
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
